[sv/radio_packet_send_queue_unit_macros.svh]
// Assertion macros for the radio packet send queue.
// Define NO_ASSERTIONS to compile every check away.
`ifndef RADIO_PACKET_SEND_QUEUE_UNIT_MACROS_SVH
`define RADIO_PACKET_SEND_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RPSQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RPSQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `RPSQ_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)
`else
`define RPSQ_ASSERT(lbl, clk, rstn, prop, msg)
`define RPSQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[sv/rpsq_pkg.sv]
// Shared types and codes of the radio packet send queue.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package rpsq_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } rpsq_state_t;

  typedef logic [1:0] rpsq_outcome_t;
  localparam rpsq_outcome_t OUTCOME_SENT   = 2'd0;
  localparam rpsq_outcome_t OUTCOME_RETRY  = 2'd1;
  localparam rpsq_outcome_t OUTCOME_RESEND = 2'd2;
  localparam rpsq_outcome_t OUTCOME_DROP   = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_DONE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic pack_wr;      // store incoming byte into the write slot
    logic enqueue;      // advance the write slot
    logic drop_rep;     // report a dropped packet
    logic evt_rep;      // report a transmit-done outcome
    logic burst_start;  // clear burst index, leave idle
    logic burst_rd;     // read one payload byte of the flight slot
  } rpsq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pkt_complete; // incoming byte closes a packet
    logic queue_full;   // no free slot beyond the write slot
    logic idle;         // nothing in flight
    logic drains;       // event leaves no packet in flight
    logic burst_end;    // current read is the final byte
  } rpsq_stat_t;

endpackage

`default_nettype wire

[sv/rpsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/rpsq_ctrl.sv]
// Controller of the radio packet send queue: accepts words, sequences bursts.
// Depends on rpsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpsq_ctrl
  import rpsq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       in_func,
  input  rpsq_stat_t      stat,
  output logic            busy,
  output rpsq_cmd_t       cmd
);

  rpsq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r == ST_BURST);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == FUNC_DATA) begin
            cmd.pack_wr = 1'b1;
            if (stat.pkt_complete) begin
              if (!stat.idle && stat.queue_full) begin
                cmd.drop_rep = 1'b1;
              end else begin
                cmd.enqueue = 1'b1;
                if (stat.idle) begin
                  cmd.burst_start = 1'b1;
                  state_nxt       = ST_BURST;
                end
              end
            end
          end else if (!stat.idle) begin
            // event while idle is ignored
            cmd.evt_rep = 1'b1;
            if (!stat.drains) begin
              cmd.burst_start = 1'b1;
              state_nxt       = ST_BURST;
            end
          end
        end
      end
      ST_BURST: begin
        cmd.burst_rd = 1'b1;
        if (stat.burst_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/rpsq_datapath.sv]
// Datapath of the radio packet send queue: slot pointers, packet RAM,
// report and payload output registers. Depends on rpsq_pkg and rpsq_ram.
`timescale 1ns / 1ps
`default_nettype none

module rpsq_datapath
  import rpsq_pkg::*;
#(
  parameter int PACKET_BYTES = 32,
  parameter int QUEUE_SLOTS  = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_sent_flag,
  input  wire logic       in_retry_limit_flag,
  input  rpsq_cmd_t       cmd,
  output rpsq_stat_t      stat,
  output logic            out_strobe,
  output logic            out_kind,
  output logic [7:0]      out_payload_byte,
  output logic            out_last,
  output logic [1:0]      out_outcome,
  output logic            out_queue_empty
);

  localparam int DEPTH = QUEUE_SLOTS * PACKET_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int IW    = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    if (s == SW'(QUEUE_SLOTS - 1)) begin
      next_slot = '0;
    end else begin
      next_slot = s + SW'(1);
    end
  endfunction

  logic [IW-1:0] pack_count_r, pack_count_nxt;
  logic [SW-1:0] write_slot_r, write_slot_nxt;
  logic [SW-1:0] flight_slot_r, flight_slot_nxt;
  logic          idle_r, idle_nxt;
  logic [IW-1:0] burst_idx_r, burst_idx_nxt;
  logic          rep_valid_r, rep_valid_nxt;
  rpsq_outcome_t rep_outcome_r, rep_outcome_nxt;
  logic          rep_last_r, rep_last_nxt;
  logic          rep_empty_r, rep_empty_nxt;
  logic          byte_valid_r, byte_valid_nxt;
  logic          byte_last_r, byte_last_nxt;

  rpsq_outcome_t evt_outcome;
  logic          retire;
  logic [SW-1:0] flight_after;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign retire       = in_retry_limit_flag | in_sent_flag;
  assign evt_outcome  = in_retry_limit_flag ? OUTCOME_RETRY :
                        (in_sent_flag ? OUTCOME_SENT : OUTCOME_RESEND);
  assign flight_after = retire ? next_slot(flight_slot_r) : flight_slot_r;

  // bytes land straight in the write slot; a dropped packet is simply not enqueued
  assign wr_addr = AW'(write_slot_r) * AW'(PACKET_BYTES) + AW'(pack_count_r);
  assign rd_addr = AW'(flight_slot_r) * AW'(PACKET_BYTES) + AW'(burst_idx_r);

  assign stat.pkt_complete = (pack_count_r == IW'(PACKET_BYTES - 1));
  assign stat.queue_full   = (next_slot(write_slot_r) == flight_slot_r);
  assign stat.idle         = idle_r;
  assign stat.drains       = (flight_after == write_slot_r);
  assign stat.burst_end    = (burst_idx_r == IW'(PACKET_BYTES - 1));

  rpsq_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.pack_wr),
    .wr_addr (wr_addr),
    .wr_data (in_data_byte),
    .rd_en   (cmd.burst_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    pack_count_nxt  = pack_count_r;
    write_slot_nxt  = write_slot_r;
    flight_slot_nxt = flight_slot_r;
    idle_nxt        = idle_r;
    burst_idx_nxt   = burst_idx_r;
    rep_valid_nxt   = cmd.drop_rep | cmd.evt_rep;
    rep_outcome_nxt = rep_outcome_r;
    rep_last_nxt    = rep_last_r;
    rep_empty_nxt   = rep_empty_r;
    byte_valid_nxt  = cmd.burst_rd;
    byte_last_nxt   = stat.burst_end;

    if (cmd.pack_wr) begin
      pack_count_nxt = stat.pkt_complete ? '0 : pack_count_r + IW'(1);
    end
    if (cmd.enqueue) begin
      write_slot_nxt = next_slot(write_slot_r);
    end
    if (cmd.drop_rep) begin
      rep_outcome_nxt = OUTCOME_DROP;
      rep_last_nxt    = 1'b1;
      rep_empty_nxt   = 1'b0;
    end
    if (cmd.evt_rep) begin
      flight_slot_nxt = flight_after;
      rep_outcome_nxt = evt_outcome;
      rep_last_nxt    = stat.drains;
      rep_empty_nxt   = stat.drains;
      idle_nxt        = stat.drains;
    end
    if (cmd.burst_start) begin
      burst_idx_nxt = '0;
      idle_nxt      = 1'b0;
    end
    if (cmd.burst_rd) begin
      burst_idx_nxt = burst_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_count_r  <= '0;
      write_slot_r  <= '0;
      flight_slot_r <= '0;
      idle_r        <= 1'b1;
      burst_idx_r   <= '0;
      rep_valid_r   <= 1'b0;
      byte_valid_r  <= 1'b0;
    end else begin
      pack_count_r  <= pack_count_nxt;
      write_slot_r  <= write_slot_nxt;
      flight_slot_r <= flight_slot_nxt;
      idle_r        <= idle_nxt;
      burst_idx_r   <= burst_idx_nxt;
      rep_valid_r   <= rep_valid_nxt;
      byte_valid_r  <= byte_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_outcome_r <= rep_outcome_nxt;
    rep_last_r    <= rep_last_nxt;
    rep_empty_r   <= rep_empty_nxt;
    byte_last_r   <= byte_last_nxt;
  end

  // report and payload words never overlap
  assign out_strobe       = rep_valid_r | byte_valid_r;
  assign out_kind         = rep_valid_r ? KIND_REPORT : KIND_PAYLOAD;
  assign out_payload_byte = byte_valid_r ? rd_data : 8'd0;
  assign out_last         = rep_valid_r ? rep_last_r : byte_last_r;
  assign out_outcome      = rep_valid_r ? rep_outcome_r : OUTCOME_SENT;
  assign out_queue_empty  = rep_valid_r & rep_empty_r;

endmodule

`default_nettype wire

[sv/radio_packet_send_queue_unit.sv]
// Channel   Handshake          Fields
// input     start / busy       in_func, in_data_byte, in_sent_flag, in_retry_limit_flag
// result    out_strobe (1 cyc) out_kind, out_payload_byte, out_last, out_outcome,
//                              out_queue_empty
// A data byte that does not start a burst leaves busy low; a report appears the cycle
// after acceptance. A burst holds busy while it reads the flight slot, one read of the
// packet RAM port per payload byte. Reset clears pointers and pack count and sets the
// idle flag; the packet RAM is not cleared and only written slots are ever read.
// Results cannot be stalled by the receiver.
// Depends on rpsq_pkg, rpsq_ctrl, rpsq_datapath and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "radio_packet_send_queue_unit_macros.svh"

module radio_packet_send_queue_unit
  import rpsq_pkg::*;
#(
  parameter int PACKET_BYTES = 32,
  parameter int QUEUE_SLOTS  = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_func,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_sent_flag,
  input  wire logic       in_retry_limit_flag,
  output logic            out_strobe,
  output logic            out_kind,
  output logic [7:0]      out_payload_byte,
  output logic            out_last,
  output logic [1:0]      out_outcome,
  output logic            out_queue_empty
);

  rpsq_cmd_t  cmd;
  rpsq_stat_t stat;

  rpsq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  rpsq_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .QUEUE_SLOTS  (QUEUE_SLOTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_data_byte        (in_data_byte),
    .in_sent_flag        (in_sent_flag),
    .in_retry_limit_flag (in_retry_limit_flag),
    .cmd                 (cmd),
    .stat                (stat),
    .out_strobe          (out_strobe),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_last            (out_last),
    .out_outcome         (out_outcome),
    .out_queue_empty     (out_queue_empty)
  );

  `RPSQ_ASSERT_IMP(a_rd_in_burst, clk, rst_n, cmd.burst_rd, busy, "burst read outside burst")
  `RPSQ_ASSERT_IMP(a_drop_busy, clk, rst_n, cmd.drop_rep, !stat.idle, "drop while idle")
  `RPSQ_ASSERT_IMP(a_empty_last, clk, rst_n, out_strobe && out_queue_empty,
                   out_kind && out_last, "empty flag on non-final word")
  `RPSQ_ASSERT_IMP(a_burst_entry, clk, rst_n, $rose(busy), $past(cmd.burst_start),
                   "burst entered without start")

endmodule

`default_nettype wire

[verif/send_queue_checker.sv]
// Watches both channels of the radio packet send queue, keeps its own copy of the
// packing buffer, slot store and pointers, and compares every strobed result word.
// Depends on rpsq_pkg for outcome and kind codes.
`timescale 1ns / 1ps

module send_queue_checker
  import rpsq_pkg::*;
#(
  parameter int PACKET_BYTES = 32,
  parameter int QUEUE_SLOTS  = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_sent_flag,
  input  logic       in_retry_limit_flag,
  input  logic       out_strobe,
  input  logic       out_kind,
  input  logic [7:0] out_payload_byte,
  input  logic       out_last,
  input  logic [1:0] out_outcome,
  input  logic       out_queue_empty,
  output int         fail_count,
  output int         words_pending
);

  typedef struct packed {
    logic          kind;
    logic [7:0]    payload_byte;
    logic          last;
    rpsq_outcome_t outcome;
    logic          queue_empty;
  } radio_word_t;

  logic [7:0]  pack_bytes [PACKET_BYTES];
  logic [7:0]  slot_bytes [QUEUE_SLOTS * PACKET_BYTES];
  int          pack_count;
  int          write_slot;
  int          flight_slot;
  logic        tx_idle;
  radio_word_t radio_words [$];

  initial fail_count = 0;
  initial words_pending = 0;

  function automatic int next_slot(input int s);
    return (s + 1) % QUEUE_SLOTS;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic push_word(input logic k, input logic [7:0] b, input logic lst,
                           input rpsq_outcome_t oc, input logic empt);
    radio_word_t w;
    w.kind = k;
    w.payload_byte = b;
    w.last = lst;
    w.outcome = oc;
    w.queue_empty = empt;
    radio_words.push_back(w);
  endtask

  task automatic push_burst(input int s);
    for (int i = 0; i < PACKET_BYTES; i++) begin
      push_word(KIND_PAYLOAD, slot_bytes[s * PACKET_BYTES + i], i == PACKET_BYTES - 1,
                OUTCOME_SENT, 1'b0);
    end
  endtask

  task automatic step_send_queue(input logic func, input logic [7:0] b,
                                 input logic sent, input logic retry);
    rpsq_outcome_t oc;
    int s;
    if (func == FUNC_DATA) begin
      pack_bytes[pack_count] = b;
      pack_count++;
      if (pack_count == PACKET_BYTES) begin
        pack_count = 0;
        if (!tx_idle && next_slot(write_slot) == flight_slot) begin
          push_word(KIND_REPORT, 8'h00, 1'b1, OUTCOME_DROP, 1'b0);
        end else begin
          for (int i = 0; i < PACKET_BYTES; i++)
            slot_bytes[write_slot * PACKET_BYTES + i] = pack_bytes[i];
          s = write_slot;
          write_slot = next_slot(write_slot);
          if (tx_idle) begin
            tx_idle = 1'b0;
            push_burst(s);
          end
        end
      end
    end else if (!tx_idle) begin
      oc = retry ? OUTCOME_RETRY : (sent ? OUTCOME_SENT : OUTCOME_RESEND);
      // a resend keeps the flight slot, anything else retires it
      if (oc != OUTCOME_RESEND) flight_slot = next_slot(flight_slot);
      if (flight_slot == write_slot) begin
        tx_idle = 1'b1;
        push_word(KIND_REPORT, 8'h00, 1'b1, oc, 1'b1);
      end else begin
        push_word(KIND_REPORT, 8'h00, 1'b0, oc, 1'b0);
        push_burst(flight_slot);
      end
    end
  endtask

  task automatic check_word();
    radio_word_t want;
    if (radio_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind %0d byte %02h last %0d outcome %0d",
                                out_kind, out_payload_byte, out_last, out_outcome));
    end else begin
      want = radio_words.pop_front();
      if (out_kind !== want.kind || out_payload_byte !== want.payload_byte ||
          out_last !== want.last || out_outcome !== want.outcome ||
          out_queue_empty !== want.queue_empty) begin
        report_mismatch($sformatf(
          "got kind %0d byte %02h last %0d outcome %0d empty %0d, want %0d %02h %0d %0d %0d",
          out_kind, out_payload_byte, out_last, out_outcome, out_queue_empty,
          want.kind, want.payload_byte, want.last, want.outcome, want.queue_empty));
      end
    end
  endtask

  // compare before predicting: a word strobed at this edge belongs to an older item
  always @(posedge clk) begin
    if (!rst_n) begin
      pack_count = 0;
      write_slot = 0;
      flight_slot = 0;
      tx_idle = 1'b1;
      radio_words.delete();
    end else begin
      if (out_strobe) check_word();
      if (start && !busy)
        step_send_queue(in_func, in_data_byte, in_sent_flag, in_retry_limit_flag);
    end
    words_pending <= radio_words.size();
  end

endmodule

[verif/testbench.sv]
// Top of the send queue testbench: clock, reset, stimulus and verdict.
// Instantiates radio_packet_send_queue_unit and send_queue_checker; uses rpsq_pkg.
`timescale 1ns / 1ps

module testbench
  import rpsq_pkg::*;
();

  localparam int PACKET_BYTES = 32;
  localparam int QUEUE_SLOTS  = 128;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_func;
  logic [7:0] in_data_byte;
  logic       in_sent_flag;
  logic       in_retry_limit_flag;
  logic       out_strobe;
  logic       out_kind;
  logic [7:0] out_payload_byte;
  logic       out_last;
  logic [1:0] out_outcome;
  logic       out_queue_empty;
  int         fail_count;
  int         words_pending;
  int         burst_left;

  radio_packet_send_queue_unit #(
    .PACKET_BYTES(PACKET_BYTES),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_data_byte       (in_data_byte),
    .in_sent_flag       (in_sent_flag),
    .in_retry_limit_flag(in_retry_limit_flag),
    .out_strobe         (out_strobe),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_last           (out_last),
    .out_outcome        (out_outcome),
    .out_queue_empty    (out_queue_empty)
  );

  send_queue_checker #(
    .PACKET_BYTES(PACKET_BYTES),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_data_byte       (in_data_byte),
    .in_sent_flag       (in_sent_flag),
    .in_retry_limit_flag(in_retry_limit_flag),
    .out_strobe         (out_strobe),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_last           (out_last),
    .out_outcome        (out_outcome),
    .out_queue_empty    (out_queue_empty),
    .fail_count         (fail_count),
    .words_pending      (words_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // idle between bursts of words, sometimes not at all
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // hold the word until an edge sees start high and busy low
  task automatic send_word(input logic func, input logic [7:0] b,
                           input logic sent, input logic retry);
    pace();
    in_func <= func;
    in_data_byte <= b;
    in_sent_flag <= sent;
    in_retry_limit_flag <= retry;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_event(input int retire_odds);
    logic retry;
    logic sent;
    if ($urandom_range(0, 99) < retire_odds) begin
      retry = 1'($urandom);
      sent = retry ? 1'($urandom) : 1'b1;
    end else begin
      retry = 1'b0;
      sent = 1'b0;
    end
    send_word(FUNC_DONE, 8'($urandom), sent, retry);
  endtask

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_DATA;
    in_data_byte = 8'h00;
    in_sent_flag = 1'b0;
    in_retry_limit_flag = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: event while idle, two packets with extreme bytes, resend, sent and retry outcomes
    send_word(FUNC_DONE, 8'hFF, 1'b1, 1'b1);
    for (int i = 0; i < PACKET_BYTES; i++)
      send_word(FUNC_DATA, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(i * 37 + 5),
                1'(i), 1'(i >> 1));
    for (int i = 0; i < PACKET_BYTES; i++)
      send_word(FUNC_DATA, (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : ~8'(i * 37 + 5),
                1'(i >> 1), 1'(i));
    send_word(FUNC_DONE, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_DONE, 8'hFF, 1'b1, 1'b0);
    send_word(FUNC_DONE, 8'h5A, 1'b1, 1'b1);
    send_word(FUNC_DONE, 8'hA5, 1'b0, 1'b1);

    // random mix, mostly data words so that packets complete
    for (int n = 0; n < 110; n++) begin
      if ($urandom_range(0, 6) == 0) send_random_event(70);
      else send_word(FUNC_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
    end

    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
